// ----- sv/gaussian_blur_12x12_rgb_assert.svh -----
// ----------------------------------------------------------------------------
// gaussian blur assertion macros
// shared concurrent assertion helpers, clocked on i_clk, reset i_rst_n
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_BLUR_12X12_RGB_ASSERT_SVH
`define GAUSSIAN_BLUR_12X12_RGB_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define GB_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// next-cycle implication
`define GB_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define GB_ASSERT_IMP(lbl, a, b)
`define GB_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ----- sv/gb12_pkg.sv -----
// ----------------------------------------------------------------------------
// gb12_pkg
// constants, types and the weight table of the 12x12 gaussian blur
// ----------------------------------------------------------------------------
`default_nettype none
package gb12_pkg;

    localparam int KSIZE     = 12;
    localparam int KLO       = KSIZE / 2;
    localparam int KHI       = KSIZE - 1 - KLO;
    localparam int LINES     = KSIZE - 1;
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = 11;
    localparam int ROW_W     = 12;
    localparam int CFG_W     = 12;
    localparam int PIX_W     = 24;
    localparam int WGT_W     = 12;
    localparam int PROD_W    = 20;
    localparam int CACC_W    = 23;
    localparam int TACC_W    = 26;
    localparam int STEP_W    = 4;
    localparam int BASE_W    = 4;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [WGT_W-1:0] WEIGHT_TBL [0:72] = '{
        12'd2608, 12'd2301, 12'd2031, 12'd1792, 12'd1582, 12'd1396, 12'd1232, 12'd1087,
        12'd959, 12'd847, 12'd747, 12'd659, 12'd582, 12'd513, 12'd453, 12'd400,
        12'd353, 12'd311, 12'd275, 12'd243, 12'd214, 12'd189, 12'd167, 12'd147,
        12'd130, 12'd115, 12'd101, 12'd89, 12'd79, 12'd69, 12'd61, 12'd54,
        12'd48, 12'd42, 12'd37, 12'd33, 12'd29, 12'd26, 12'd23, 12'd20,
        12'd18, 12'd16, 12'd14, 12'd12, 12'd11, 12'd9, 12'd8, 12'd7,
        12'd6, 12'd6, 12'd5, 12'd4, 12'd4, 12'd3, 12'd3, 12'd3,
        12'd2, 12'd2, 12'd2, 12'd2, 12'd1, 12'd1, 12'd1, 12'd1,
        12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd0, 12'd0, 12'd0,
        12'd0
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_SUM,
        ST_EMIT_B,
        ST_EMIT_C
    } t_state;

    typedef struct packed {
        logic              shift;
        logic              rot;
        logic              clr;
        logic              mac;
        logic              pass;
        logic [STEP_W-1:0] step;
    } t_cell_ctrl;

    typedef logic [2:0][CACC_W-1:0] t_acc;

    // weight for window row wr, column wc
    function automatic logic [WGT_W-1:0] weight_at(input logic [STEP_W-1:0] wr,
                                                   input logic [STEP_W-1:0] wc);
        logic [STEP_W-1:0] ax;
        logic [STEP_W-1:0] ay;
        logic [6:0]        d2;
        ax = (wc >= STEP_W'(KLO)) ? wc - STEP_W'(KLO) : STEP_W'(KLO) - wc;
        ay = (wr >= STEP_W'(KLO)) ? wr - STEP_W'(KLO) : STEP_W'(KLO) - wr;
        d2 = 7'({3'b0, ax} * {3'b0, ax}) + 7'({3'b0, ay} * {3'b0, ay});
        return WEIGHT_TBL[d2];
    endfunction

endpackage
`default_nettype wire

// ----- sv/gb12_ram.sv -----
// ----------------------------------------------------------------------------
// gb12_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module gb12_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- sv/gb12_cell.sv -----
// ----------------------------------------------------------------------------
// gb12_cell
// one window row: twelve pixels, a rotating multiply-accumulate per channel
// ----------------------------------------------------------------------------
`default_nettype none
module gb12_cell
    import gb12_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_ctrl        i_ctrl,
    input  wire logic [STEP_W-1:0] i_row_idx,
    input  wire logic [PIX_W-1:0]  i_pix,
    input  wire t_acc              i_acc,
    output t_acc                   o_acc
);

    logic [PIX_W-1:0] r_pix [KSIZE];
    logic [PIX_W-1:0] n_pix [KSIZE];
    t_acc             r_acc;
    t_acc             n_acc;
    logic [WGT_W-1:0] w;

    assign w = weight_at(i_row_idx, i_ctrl.step);

    always_comb begin
        for (int k = 0; k < KSIZE; k++) begin
            n_pix[k] = r_pix[k];
        end
        if (i_ctrl.shift || i_ctrl.rot) begin
            for (int k = 0; k < KSIZE - 1; k++) begin
                n_pix[k] = r_pix[k+1];
            end
            n_pix[KSIZE-1] = i_ctrl.shift ? i_pix : r_pix[0];
        end
    end

    // head pixel is original column i_ctrl.step while rotating
    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.clr) begin
            n_acc = '0;
        end else if (i_ctrl.mac) begin
            for (int ch = 0; ch < 3; ch++) begin
                n_acc[ch] = r_acc[ch] + CACC_W'(PROD_W'(r_pix[0][ch*8 +: 8]) * PROD_W'(w));
            end
        end else if (i_ctrl.pass) begin
            n_acc = i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KSIZE; k++) begin
                r_pix[k] <= '0;
            end
            r_acc <= '0;
        end else begin
            r_pix <= n_pix;
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule
`default_nettype wire

// ----- sv/gaussian_blur_12x12_rgb.sv -----
// ----------------------------------------------------------------------------
// gaussian_blur_12x12_rgb
// 12x12 gaussian blur over a raster rgb stream, borders copied through
// ----------------------------------------------------------------------------
// one pixel at a time: a new pixel is taken only in the idle state. each pixel
// is read in; when an interior center is due the row cells then rotate through
// their pixels and drain their partial sums down the cell chain, and each result
// is held until it is taken. the rotation and the drain set the pixel rate.
// synchronous active-low reset clears counters, state, size registers and the
// window, not the payload registers; the line store needs no clearing pass.
`default_nettype none
module gaussian_blur_12x12_rgb
    import gb12_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic             i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [7:0]       i_red_in,
    input  wire logic [7:0]       i_green_in,
    input  wire logic [7:0]       i_blue_in,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [COL_W-1:0]      o_out_column,
    output logic [ROW_W-1:0]      o_out_row,
    output logic [7:0]            o_red_out,
    output logic [7:0]            o_green_out,
    output logic [7:0]            o_blue_out,
    output logic [7:0]            o_alpha_out,
    output logic                  o_last_of_item
);

`include "gaussian_blur_12x12_rgb_assert.svh"

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_width, r_height;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [BASE_W-1:0] r_line_base;
    logic [STEP_W-1:0] r_step;
    logic [PIX_W-1:0]  r_px;
    logic              r_border, r_center;
    logic [COL_W-1:0]  r_bcol, r_ccol;
    logic [ROW_W-1:0]  r_brow, r_crow;
    logic [2:0][TACC_W-1:0] r_total;

    logic              accept;
    logic [CFG_W-1:0]  w_eff, h_eff;
    logic              border_now, center_now;
    logic [COL_W-1:0]  ccol;
    logic [ROW_W-1:0]  crow;
    logic [PIX_W-1:0]  ram_rd [LINES];
    logic [PIX_W-1:0]  row_in [KSIZE];
    t_acc              cell_acc [KSIZE];
    t_acc              cell_in [KSIZE];
    t_cell_ctrl        ctrl;
    logic [7:0]        blur_ch [3];

    assign accept = i_valid && !o_stall;
    // no transfer is taken while reset is held
    assign o_stall = !i_rst_n || (r_state != ST_IDLE);

    assign w_eff = (r_width == '0) ? CFG_W'(1) :
                   (r_width > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : r_width;
    assign h_eff = (r_height == '0) ? CFG_W'(1) : r_height;

    function automatic logic is_border(input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r,
                                       input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        return (c < COL_W'(KLO)) || ({2'b0, c} + 13'(KLO) > {1'b0, w}) ||
               (r < ROW_W'(KLO)) || ({1'b0, r} + 13'(KLO) > {1'b0, h});
    endfunction

    assign ccol = r_col - COL_W'(KHI);
    assign crow = r_row - ROW_W'(KHI);
    assign border_now = is_border(r_col, r_row, w_eff, h_eff);
    assign center_now = (r_col >= COL_W'(KHI)) && (r_row >= ROW_W'(KHI)) &&
                        !is_border(ccol, crow, w_eff, h_eff);

    // line store: one ram per buffered line, all read at the current column
    for (genvar g = 0; g < LINES; g++) begin : g_line
        gb12_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (r_state == ST_READ && r_line_base == BASE_W'(g)),
            .i_wr_addr (r_col),
            .i_wr_data (r_px),
            .i_rd_en   (accept),
            .i_rd_addr (r_col),
            .o_rd_data (ram_rd[g])
        );
    end

    // window row r takes line (base + r) mod lines
    for (genvar g = 0; g < LINES; g++) begin : g_map
        logic [BASE_W:0] idx;
        logic [BASE_W:0] idx_w;
        assign idx   = {1'b0, r_line_base} + (BASE_W+1)'(g);
        assign idx_w = (idx >= (BASE_W+1)'(LINES)) ? idx - (BASE_W+1)'(LINES) : idx;
        assign row_in[g] = ram_rd[idx_w[BASE_W-1:0]];
    end
    assign row_in[KSIZE-1] = r_px;

    always_comb begin
        ctrl.shift = (r_state == ST_READ);
        ctrl.clr   = (r_state == ST_READ);
        ctrl.rot   = (r_state == ST_MAC);
        ctrl.mac   = (r_state == ST_MAC);
        ctrl.pass  = (r_state == ST_SUM);
        ctrl.step  = r_step;
    end

    for (genvar g = 0; g < KSIZE; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign cell_in[g] = '0;
        end else begin : g_link
            assign cell_in[g] = cell_acc[g-1];
        end
        gb12_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (ctrl),
            .i_row_idx (STEP_W'(g)),
            .i_pix     (row_in[g]),
            .i_acc     (cell_in[g]),
            .o_acc     (cell_acc[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_READ;
            end
            ST_READ: begin
                if (center_now)      n_state = ST_MAC;
                else if (border_now) n_state = ST_EMIT_B;
                else                 n_state = ST_IDLE;
            end
            ST_MAC: begin
                if (r_step == STEP_W'(KSIZE-1)) n_state = ST_SUM;
            end
            ST_SUM: begin
                if (r_step == STEP_W'(KSIZE-1)) n_state = r_border ? ST_EMIT_B : ST_EMIT_C;
            end
            ST_EMIT_B: begin
                if (!i_stall) n_state = r_center ? ST_EMIT_C : ST_IDLE;
            end
            ST_EMIT_C: begin
                if (!i_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_width     <= WIDTH_RESET;
            r_height    <= HEIGHT_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_line_base <= '0;
            r_step      <= '0;
            r_border    <= 1'b0;
            r_center    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                if (i_cfg_index == REG_WIDTH) r_width  <= i_cfg_data;
                else                          r_height <= i_cfg_data;
            end
            if (r_state == ST_MAC || r_state == ST_SUM) begin
                r_step <= (r_step == STEP_W'(KSIZE-1)) ? '0 : r_step + 1'b1;
            end
            if (r_state == ST_READ) begin
                r_border <= border_now;
                r_center <= center_now;
                if ({1'b0, r_col} + 12'd1 >= w_eff) begin
                    r_col <= '0;
                    if ({1'b0, r_row} + 13'd1 >= {1'b0, h_eff}) begin
                        r_row       <= '0;
                        r_line_base <= '0;
                    end else begin
                        r_row       <= r_row + 1'b1;
                        r_line_base <= (r_line_base == BASE_W'(LINES-1)) ? '0
                                                                         : r_line_base + 1'b1;
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px <= {i_red_in, i_green_in, i_blue_in};
        end
        if (r_state == ST_READ) begin
            r_bcol <= r_col;
            r_brow <= r_row;
            r_ccol <= ccol;
            r_crow <= crow;
            r_total <= '0;
        end else if (r_state == ST_SUM) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_total[ch] <= r_total[ch] + TACC_W'(cell_acc[KSIZE-1][ch]);
            end
        end
    end

    // round half up, saturate at 255
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            logic [TACC_W-1:0] rnd;
            rnd = r_total[ch] + TACC_W'(32768);
            blur_ch[ch] = (rnd[TACC_W-1:16] > 10'd255) ? 8'd255 : rnd[23:16];
        end
    end

    // output mux
    always_comb begin
        o_valid        = (r_state == ST_EMIT_B) || (r_state == ST_EMIT_C);
        o_alpha_out    = 8'd255;
        o_out_column   = r_bcol;
        o_out_row      = r_brow;
        o_red_out      = r_px[23:16];
        o_green_out    = r_px[15:8];
        o_blue_out     = r_px[7:0];
        o_last_of_item = !r_center;
        if (r_state == ST_EMIT_C) begin
            o_out_column   = r_ccol;
            o_out_row      = r_crow;
            o_red_out      = blur_ch[2];
            o_green_out    = blur_ch[1];
            o_blue_out     = blur_ch[0];
            o_last_of_item = 1'b1;
        end
    end

    `GB_ASSERT_IMP(a_out_blocks_in, o_valid, o_stall)
    `GB_ASSERT_IMP(a_base_range, 1'b1, r_line_base < BASE_W'(LINES))
    `GB_ASSERT_IMP(a_center_last, o_valid && r_state == ST_EMIT_C, o_last_of_item)
    `GB_ASSERT_NEXT(a_mac_to_sum, r_state == ST_MAC && r_step == STEP_W'(KSIZE-1), r_state == ST_SUM)

endmodule
`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// checks the 12x12 gaussian blur against a pixel-exact predictor over
// several frame sizes, with random gaps on the pixel input and random stalls
// on the result output
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    import gb12_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int SETTLE = 40;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic             last;
    } t_blur_result;

    // round(65536 * exp(-d/8) / (8*pi)) by squared distance
    localparam int GAUSS_Q16 [0:72] = '{
        2608, 2301, 2031, 1792, 1582, 1396, 1232, 1087, 959, 847,
        747, 659, 582, 513, 453, 400, 353, 311, 275, 243,
        214, 189, 167, 147, 130, 115, 101, 89, 79, 69,
        61, 54, 48, 42, 37, 33, 29, 26, 23, 20,
        18, 16, 14, 12, 11, 9, 8, 7, 6, 6,
        5, 4, 4, 3, 3, 3, 2, 2, 2, 2,
        1, 1, 1, 1, 1, 1, 1, 1, 1, 0,
        0, 0, 0
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic             i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_valid;
    logic             o_stall;
    logic [7:0]       i_red_in;
    logic [7:0]       i_green_in;
    logic [7:0]       i_blue_in;
    logic             o_valid;
    logic             i_stall;
    logic [COL_W-1:0] o_out_column;
    logic [ROW_W-1:0] o_out_row;
    logic [7:0]       o_red_out;
    logic [7:0]       o_green_out;
    logic [7:0]       o_blue_out;
    logic [7:0]       o_alpha_out;
    logic             o_last_of_item;

    gaussian_blur_12x12_rgb dut (.*);

    t_pixel       pixel_q[$];
    t_blur_result blur_q[$];
    int           errors;
    int           cycles;
    logic         calm;

    // predictor state
    logic [23:0]      line_mem [0:LINES-1][0:MAX_WIDTH-1];
    logic [23:0]      win [0:KSIZE-1][0:KSIZE-1];
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        // long quiet window with no gaps and no stalls
        calm <= (cycles >= 500 && cycles < 1500);
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic report(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    function automatic logic [7:0] round_sat(input int unsigned acc);
        int unsigned v;
        v = (acc + 32768) >> 16;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [23:0] blur_center();
        int unsigned acc_r, acc_g, acc_b, wt;
        int dx, dy, d2;
        acc_r = 0;
        acc_g = 0;
        acc_b = 0;
        for (int wr = 0; wr < KSIZE; wr++) begin
            for (int wc = 0; wc < KSIZE; wc++) begin
                dx = wc - KLO;
                dy = wr - KLO;
                d2 = dx * dx + dy * dy;
                wt = (d2 < 73) ? GAUSS_Q16[d2] : 0;
                acc_r += win[wr][wc][23:16] * wt;
                acc_g += win[wr][wc][15:8] * wt;
                acc_b += win[wr][wc][7:0] * wt;
            end
        end
        return {round_sat(acc_r), round_sat(acc_g), round_sat(acc_b)};
    endfunction

    function automatic bit on_border(input int unsigned c, input int unsigned r,
                                     input int unsigned w, input int unsigned h);
        return c < KLO || c + KLO > w || r < KLO || r + KLO > h;
    endfunction

    function automatic void push_result(input int unsigned c, input int unsigned r,
                                        input logic [23:0] rgb);
        t_blur_result e;
        e.column = c[COL_W-1:0];
        e.row    = r[ROW_W-1:0];
        e.red    = rgb[23:16];
        e.green  = rgb[15:8];
        e.blue   = rgb[7:0];
        e.last   = 1'b1;
        blur_q.push_back(e);
    endfunction

    // advance the predictor by one pixel and queue what it emits
    function automatic void predict_pixel(input t_pixel p);
        int unsigned w, h, c, r;
        logic [23:0] px;
        bit          copied;
        w  = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h  = (height_reg == 0) ? 1 : height_reg;
        px = {p.red, p.green, p.blue};
        for (int wr = 0; wr < KSIZE; wr++) begin
            for (int wc = 0; wc < KSIZE - 1; wc++) win[wr][wc] = win[wr][wc+1];
            win[wr][KSIZE-1] = (wr < KSIZE - 1) ?
                line_mem[(row_cnt + wr) % LINES][col_cnt] : px;
        end
        line_mem[row_cnt % LINES][col_cnt] = px;
        copied = on_border(col_cnt, row_cnt, w, h);
        if (copied) push_result(col_cnt, row_cnt, px);
        if (col_cnt >= KHI && row_cnt >= KHI) begin
            c = col_cnt - KHI;
            r = row_cnt - KHI;
            if (!on_border(c, r, w, h)) begin
                if (copied) blur_q[$].last = 1'b0;
                push_result(c, r, blur_center());
            end
        end
        if (col_cnt + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
        end else begin
            col_cnt = col_cnt + 1;
        end
    endfunction

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        t_pixel p;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        predict_pixel(p);
        pixel_q.push_back(p);
    endtask

    function automatic logic [7:0] rand_level();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return 8'd0;
        if (sel == 1) return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_random(input int n);
        for (int k = 0; k < n; k++) send_pixel(rand_level(), rand_level(), rand_level());
    endtask

    task automatic send_to_frame_end();
        do send_random(1); while (!(col_cnt == 0 && row_cnt == 0));
    endtask

    task automatic wait_drained();
        while (pixel_q.size() != 0 || i_valid || blur_q.size() != 0) @(posedge i_clk);
        // pixels with no result may still be in flight
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == REG_WIDTH) width_reg = val;
        else height_reg = val;
    endtask

    task automatic resize(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_drained();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // pixel source
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (pixel_q.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
                i_red_in   <= pixel_q[0].red;
                i_green_in <= pixel_q[0].green;
                i_blue_in  <= pixel_q[0].blue;
                i_valid    <= 1'b1;
                void'(pixel_q.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result sink and checker
    always @(posedge i_clk) begin
        t_blur_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (blur_q.size() == 0) begin
                report($sformatf("unexpected result at col %0d row %0d",
                                 o_out_column, o_out_row));
            end else begin
                e = blur_q.pop_front();
                if (o_out_column !== e.column)
                    report($sformatf("column %0d, want %0d", o_out_column, e.column));
                if (o_out_row !== e.row)
                    report($sformatf("row %0d, want %0d", o_out_row, e.row));
                if (o_red_out !== e.red)
                    report($sformatf("red %0d, want %0d at (%0d,%0d)",
                                     o_red_out, e.red, e.column, e.row));
                if (o_green_out !== e.green)
                    report($sformatf("green %0d, want %0d at (%0d,%0d)",
                                     o_green_out, e.green, e.column, e.row));
                if (o_blue_out !== e.blue)
                    report($sformatf("blue %0d, want %0d at (%0d,%0d)",
                                     o_blue_out, e.blue, e.column, e.row));
                if (o_alpha_out !== 8'd255)
                    report($sformatf("alpha %0d at (%0d,%0d)", o_alpha_out, e.column, e.row));
                if (o_last_of_item !== e.last)
                    report($sformatf("last %0d, want %0d at (%0d,%0d)",
                                     o_last_of_item, e.last, e.column, e.row));
            end
        end
        i_stall <= calm ? 1'b0 : ($urandom_range(99) < 33);
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = REG_WIDTH;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_red_in    = '0;
        i_green_in  = '0;
        i_blue_in   = '0;
        i_stall     = 1'b0;
        errors      = 0;
        cycles      = 0;
        calm        = 1'b0;
        col_cnt     = 0;
        row_cnt     = 0;
        width_reg   = WIDTH_RESET;
        height_reg  = HEIGHT_RESET;
        for (int l = 0; l < LINES; l++)
            for (int c = 0; c < MAX_WIDTH; c++) line_mem[l][c] = '0;
        for (int r = 0; r < KSIZE; r++)
            for (int c = 0; c < KSIZE; c++) win[r][c] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset size, first line: extremes and bit patterns, all copied through
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'hAA, 8'h55, 8'hAA);
        send_pixel(8'h55, 8'hAA, 8'h55);
        for (int k = 0; k < 8; k++)
            send_pixel(8'(1 << k), 8'(~(1 << k)), 8'(1 << k));

        // shrink mid-line: current column lies past the new width
        resize(12'd12, 12'd12);
        send_to_frame_end();
        // smallest frame with an interior pixel, saturating content
        for (int k = 0; k < 144; k++) send_pixel(8'd255, 8'd255, 8'd255);

        // width over the maximum saturates
        resize(12'd4095, 12'd1);
        send_random(10);
        // zero sizes count as one, column left past the width
        resize(12'd0, 12'd0);
        send_random(6);

        // well-formed frame with random content
        resize(12'd16, 12'd14);
        send_random(16 * 14);

        wait_drained();
        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
